### design/msdc_pkg.sv
// Shared types, widths and codes of the message sequence duplicate checker.
`default_nettype none

package msdc_pkg;

  // Field and register widths
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PID_W      = 9;
  localparam int unsigned MPP_W      = 17;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned PROD_W     = PID_W + MPP_W;
  localparam int unsigned IDX_W      = PROD_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned VERDICT_W  = 3;

  // Seen-bit store organization
  localparam int unsigned STORE_BITS_DEF = 65536;
  localparam int unsigned ROW_W          = 32;
  localparam int unsigned BIT_AW         = $clog2(ROW_W);

  // Sentinel id and register reset values
  localparam logic [FIELD_W-1:0] SENTINEL_ID   = '1;
  localparam logic [PID_W-1:0]   PC_RESET      = PID_W'(1);
  localparam logic [MPP_W-1:0]   MPP_RESET     = MPP_W'(1);
  localparam logic [LEN_W-1:0]   EXP_LEN_RESET = LEN_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRODUCER_COUNT = 2'd0,
    CFG_MSGS_PER_PROD  = 2'd1,
    CFG_EXPECTED_LEN   = 2'd2
  } cfg_idx_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_NEW       = 3'd0,
    VERDICT_DUPLICATE = 3'd1,
    VERDICT_RANGE     = 3'd2,
    VERDICT_MALFORMED = 3'd3,
    VERDICT_END       = 3'd4,
    VERDICT_STOPPED   = 3'd5
  } verdict_e;

  // Header classification handed from the front stage to the tally stage
  typedef struct packed {
    logic              sentinel;
    logic              malformed;
    logic              lookup;
    logic [BIT_AW-1:0] bit_sel;
  } msdc_req_t;

endpackage

`default_nettype wire

### design/msdc_if.sv
// Valid/ready channel interfaces for message headers and results.
`default_nettype none

interface msdc_hdr_if import msdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] src_id;
  logic [FIELD_W-1:0] seq;
  logic [FIELD_W-1:0] body_len;

  modport source (output valid, output src_id, output seq, output body_len,
                  input ready);
  modport sink   (input valid, input src_id, input seq, input body_len,
                  output ready);
endinterface

interface msdc_res_if import msdc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [CNT_W-1:0]     received_count;
  logic [CNT_W-1:0]     duplicate_count;
  logic [CNT_W-1:0]     out_of_range_count;
  logic [CNT_W-1:0]     malformed_count;

  modport source (output valid, output verdict, output received_count,
                  output duplicate_count, output out_of_range_count,
                  output malformed_count, input ready);
  modport sink   (input valid, input verdict, input received_count,
                  input duplicate_count, input out_of_range_count,
                  input malformed_count, output ready);
endinterface

`default_nettype wire

### design/msdc_seen_mem.sv
// Seen-bit store: row memory with registered read and a clearing sweep after reset.
`default_nettype none

module msdc_seen_mem import msdc_pkg::*; #(
  parameter int unsigned STORE_BITS = STORE_BITS_DEF,
  localparam int unsigned ROWS   = (STORE_BITS + ROW_W - 1) / ROW_W,
  localparam int unsigned ROW_AW = $clog2(ROWS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ROW_AW-1:0] rd_row_i,
  output      logic [ROW_W-1:0]  rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ROW_AW-1:0] wr_row_i,
  input  wire logic [ROW_W-1:0]  wr_data_i,
  output      logic              busy_o
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } clr_state_e;

  clr_state_e        state_q, state_d;
  logic [ROW_AW-1:0] clr_row_q, clr_row_d;
  logic [ROW_W-1:0]  mem_q [ROWS];
  logic [ROW_W-1:0]  rd_data_q;
  logic              mem_we;
  logic [ROW_AW-1:0] mem_wa;
  logic [ROW_W-1:0]  mem_wd;

  // Sweep one row per cycle until the last row is cleared
  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_row_d = clr_row_q + ROW_AW'(1);
        if (clr_row_q == ROW_AW'(ROWS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_row_d = clr_row_q;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
    end
  end

  assign busy_o = (state_q != ST_RUN);

  // Share the write port between the sweep and the lookup pipeline
  assign mem_we = busy_o || wr_en_i;
  assign mem_wa = busy_o ? clr_row_q : wr_row_i;
  assign mem_wd = busy_o ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### design/msdc_front.sv
// Front stage: header classification, index multiply and store address.
`default_nettype none

module msdc_front import msdc_pkg::*; #(
  parameter int unsigned STORE_BITS = STORE_BITS_DEF,
  localparam int unsigned ROWS   = (STORE_BITS + ROW_W - 1) / ROW_W,
  localparam int unsigned ROW_AW = $clog2(ROWS)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               hdr_valid_i,
  input  wire logic [FIELD_W-1:0] src_id_i,
  input  wire logic [FIELD_W-1:0] seq_i,
  input  wire logic [FIELD_W-1:0] body_len_i,
  output      logic               hdr_ready_o,
  input  wire logic               busy_i,
  input  wire logic [PID_W-1:0]   producer_count_i,
  input  wire logic [MPP_W-1:0]   msgs_per_prod_i,
  input  wire logic [LEN_W-1:0]   expected_len_i,
  output      logic               req_valid_o,
  output      msdc_req_t          req_o,
  output      logic [ROW_AW-1:0]  req_row_o,
  input  wire logic               req_ready_i
);

  logic              valid_q;
  logic              sentinel_q;
  logic              malformed_q;
  logic              in_range_q;
  logic [PROD_W-1:0] prod_q;
  logic [MPP_W-1:0]  seq_q;
  logic              load;
  logic [IDX_W-1:0]  idx;

  // Accept while the stage is empty or draining, never during the store sweep
  assign hdr_ready_o = !busy_i && (!valid_q || req_ready_i);
  assign load        = hdr_valid_i && hdr_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (hdr_ready_o) begin
      valid_q <= hdr_valid_i;
    end
  end

  // Classify the header and form producer * messages per producer
  always_ff @(posedge clk_i) begin
    if (load) begin
      sentinel_q  <= (src_id_i == SENTINEL_ID);
      malformed_q <= (body_len_i != {{(FIELD_W - LEN_W){1'b0}}, expected_len_i});
      in_range_q  <= (src_id_i < {{(FIELD_W - PID_W){1'b0}}, producer_count_i})
                  && (seq_i < {{(FIELD_W - MPP_W){1'b0}}, msgs_per_prod_i});
      prod_q      <= PROD_W'(src_id_i[PID_W-1:0]) * PROD_W'(msgs_per_prod_i);
      seq_q       <= seq_i[MPP_W-1:0];
    end
  end

  // Add the sequence number and check the index against the store size
  assign idx = {1'b0, prod_q} + {{(IDX_W - MPP_W){1'b0}}, seq_q};

  assign req_valid_o       = valid_q;
  assign req_o.sentinel    = sentinel_q;
  assign req_o.malformed   = malformed_q;
  assign req_o.lookup      = in_range_q && (idx < IDX_W'(STORE_BITS));
  assign req_o.bit_sel     = idx[BIT_AW-1:0];
  assign req_row_o         = idx[BIT_AW +: ROW_AW];

endmodule

`default_nettype wire

### design/msdc_tally.sv
// Tally stage: seen-bit test and set with forwarding, counters, run end and result register.
`default_nettype none

module msdc_tally import msdc_pkg::*; #(
  parameter int unsigned STORE_BITS = STORE_BITS_DEF,
  localparam int unsigned ROWS   = (STORE_BITS + ROW_W - 1) / ROW_W,
  localparam int unsigned ROW_AW = $clog2(ROWS)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  input  wire msdc_req_t            req_i,
  input  wire logic [ROW_AW-1:0]    req_row_i,
  output      logic                 req_ready_o,
  output      logic                 rd_en_o,
  output      logic [ROW_AW-1:0]    rd_row_o,
  input  wire logic [ROW_W-1:0]     rd_data_i,
  output      logic                 wr_en_o,
  output      logic [ROW_AW-1:0]    wr_row_o,
  output      logic [ROW_W-1:0]     wr_data_o,
  output      logic                 res_valid_o,
  input  wire logic                 res_ready_i,
  output      logic [VERDICT_W-1:0] verdict_o,
  output      logic [CNT_W-1:0]     received_o,
  output      logic [CNT_W-1:0]     duplicate_o,
  output      logic [CNT_W-1:0]     range_o,
  output      logic [CNT_W-1:0]     malformed_o
);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  logic              c_valid_q;
  msdc_req_t         c_req_q;
  logic [ROW_AW-1:0] c_row_q;
  logic              fwd_hit_q;
  logic [ROW_W-1:0]  fwd_word_q;
  logic              out_valid_q;
  logic              out_free;
  logic              c_adv;
  logic              c_load;
  logic [ROW_W-1:0]  cur_word;
  logic              seen;
  verdict_e          verdict;
  logic              run_q, run_d;
  logic [CNT_W-1:0]  rcv_q, rcv_d;
  logic [CNT_W-1:0]  dup_q, dup_d;
  logic [CNT_W-1:0]  rng_q, rng_d;
  logic [CNT_W-1:0]  mal_q, mal_d;

  // Pipeline handshake between this stage and the result register
  assign out_free    = !out_valid_q || res_ready_i;
  assign c_adv       = c_valid_q && out_free;
  assign req_ready_o = !c_valid_q || out_free;
  assign c_load      = req_valid_i && req_ready_o;

  // Read the row as the transaction enters the stage
  assign rd_en_o  = c_load && req_i.lookup;
  assign rd_row_o = req_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (req_ready_o) begin
      c_valid_q <= req_valid_i;
    end
  end

  // Capture the request and any write that lands in the same cycle as the read
  always_ff @(posedge clk_i) begin
    if (c_load) begin
      c_req_q    <= req_i;
      c_row_q    <= req_row_i;
      fwd_hit_q  <= wr_en_o && (wr_row_o == req_row_i);
      fwd_word_q <= wr_data_o;
    end
  end

  assign cur_word = fwd_hit_q ? fwd_word_q : rd_data_i;
  assign seen     = cur_word[c_req_q.bit_sel];

  // Decide the verdict and the counter updates
  always_comb begin
    verdict = VERDICT_STOPPED;
    run_d   = run_q;
    rcv_d   = rcv_q;
    dup_d   = dup_q;
    rng_d   = rng_q;
    mal_d   = mal_q;
    if (!run_q) begin
      if (c_req_q.sentinel) begin
        verdict = VERDICT_END;
        run_d   = 1'b1;
      end else if (c_req_q.malformed) begin
        verdict = VERDICT_MALFORMED;
        mal_d   = sat_inc(mal_q);
      end else begin
        rcv_d = sat_inc(rcv_q);
        if (!c_req_q.lookup) begin
          verdict = VERDICT_RANGE;
          rng_d   = sat_inc(rng_q);
        end else if (seen) begin
          verdict = VERDICT_DUPLICATE;
          dup_d   = sat_inc(dup_q);
        end else begin
          verdict = VERDICT_NEW;
        end
      end
    end
  end

  // Set the seen bit for a new message
  assign wr_en_o   = c_adv && (verdict == VERDICT_NEW);
  assign wr_row_o  = c_row_q;
  assign wr_data_o = cur_word | (ROW_W'(1) << c_req_q.bit_sel);

  // Commit state as the transaction leaves the stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      rcv_q <= '0;
      dup_q <= '0;
      rng_q <= '0;
      mal_q <= '0;
    end else if (c_adv) begin
      run_q <= run_d;
      rcv_q <= rcv_d;
      dup_q <= dup_d;
      rng_q <= rng_d;
      mal_q <= mal_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_adv) begin
      verdict_o   <= verdict;
      received_o  <= rcv_d;
      duplicate_o <= dup_d;
      range_o     <= rng_d;
      malformed_o <= mal_d;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

`default_nettype wire

### design/message_sequence_duplicate_checker_top.sv
// Top level of the message sequence duplicate checker.
//
//  channel  dir  handshake             payload
//  hdr_i    in   hdr_i.valid/ready     src_id, seq, body_len
//  res_o    out  res_o.valid/ready     verdict, four saturating counts
//  cfg      in   cfg_we_i              cfg_idx_i, cfg_data_i
//
// One header per cycle unless stalled; it passes front, tally and result registers.
// The per-item cost is one read-modify-write of a 32-bit row of the seen-bit memory;
// a write landing in the cycle of a later read of the same row is forwarded.
// After reset the memory is swept, one row per cycle over all ceil(STORE_BITS/32) rows
// (2048 at the default size), with hdr_i.ready low; configuration writes are taken.
// A stalled result holds in the output register while the pipeline keeps filling.
`default_nettype none

module message_sequence_duplicate_checker_top import msdc_pkg::*; #(
  parameter int unsigned STORE_BITS = STORE_BITS_DEF,
  localparam int unsigned ROWS   = (STORE_BITS + ROW_W - 1) / ROW_W,
  localparam int unsigned ROW_AW = $clog2(ROWS)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  msdc_hdr_if.sink                   hdr_i,
  msdc_res_if.source                 res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [PID_W-1:0]  pc_q;
  logic [MPP_W-1:0]  mpp_q;
  logic [LEN_W-1:0]  exp_len_q;
  logic              busy;
  logic              req_valid;
  msdc_req_t         req;
  logic [ROW_AW-1:0] req_row;
  logic              req_ready;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_row;
  logic [ROW_W-1:0]  rd_data;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_row;
  logic [ROW_W-1:0]  wr_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= PC_RESET;
      mpp_q     <= MPP_RESET;
      exp_len_q <= EXP_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRODUCER_COUNT: pc_q      <= cfg_data_i[PID_W-1:0];
        CFG_MSGS_PER_PROD:  mpp_q     <= cfg_data_i[MPP_W-1:0];
        CFG_EXPECTED_LEN:   exp_len_q <= cfg_data_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  msdc_front #(
    .STORE_BITS (STORE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hdr_valid_i      (hdr_i.valid),
    .src_id_i         (hdr_i.src_id),
    .seq_i            (hdr_i.seq),
    .body_len_i       (hdr_i.body_len),
    .hdr_ready_o      (hdr_i.ready),
    .busy_i           (busy),
    .producer_count_i (pc_q),
    .msgs_per_prod_i  (mpp_q),
    .expected_len_i   (exp_len_q),
    .req_valid_o      (req_valid),
    .req_o            (req),
    .req_row_o        (req_row),
    .req_ready_i      (req_ready)
  );

  msdc_seen_mem #(
    .STORE_BITS (STORE_BITS)
  ) u_seen_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_row_i  (wr_row),
    .wr_data_i (wr_data),
    .busy_o    (busy)
  );

  msdc_tally #(
    .STORE_BITS (STORE_BITS)
  ) u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_row_i   (req_row),
    .req_ready_o (req_ready),
    .rd_en_o     (rd_en),
    .rd_row_o    (rd_row),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_row_o    (wr_row),
    .wr_data_o   (wr_data),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .verdict_o   (res_o.verdict),
    .received_o  (res_o.received_count),
    .duplicate_o (res_o.duplicate_count),
    .range_o     (res_o.out_of_range_count),
    .malformed_o (res_o.malformed_count)
  );

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the message sequence duplicate checker top level.
module tb;
  import msdc_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 244;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned RECENT_DEPTH = 16;

  typedef struct {
    logic [FIELD_W-1:0] pid;
    logic [FIELD_W-1:0] seq;
    logic [FIELD_W-1:0] plen;
  } header_t;

  typedef struct {
    verdict_e         verdict;
    logic [CNT_W-1:0] received;
    logic [CNT_W-1:0] duplicates;
    logic [CNT_W-1:0] range_errors;
    logic [CNT_W-1:0] malformed;
  } tally_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  msdc_hdr_if hdr_ch ();
  msdc_res_if res_ch ();

  message_sequence_duplicate_checker_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hdr_i      (hdr_ch.sink),
    .res_o      (res_ch.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: settings, seen-bit map and running totals
  logic [PID_W-1:0] cfg_producers;
  logic [MPP_W-1:0] cfg_msgs;
  logic [LEN_W-1:0] cfg_len;
  bit               seen_map [STORE_BITS_DEF];
  logic [CNT_W-1:0] rcv_total, dup_total, rng_total, mal_total;
  bit               run_done;

  header_t     header_queue [$];
  header_t     recent_hdrs [$];
  tally_t      due_tallies [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned result_index;
  int unsigned cycle_count;
  bit          pressure_go;
  logic        rx_hold;

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Classify one accepted header and advance the totals
  function automatic tally_t tally_header(input header_t h);
    tally_t      t;
    logic [63:0] slot;
    slot = 64'(h.pid) * 64'(cfg_msgs) + 64'(h.seq);
    if (run_done) begin
      t.verdict = VERDICT_STOPPED;
    end else if (h.pid == SENTINEL_ID) begin
      run_done  = 1'b1;
      t.verdict = VERDICT_END;
    end else if (h.plen != 32'(cfg_len)) begin
      mal_total = sat_bump(mal_total);
      t.verdict = VERDICT_MALFORMED;
    end else begin
      rcv_total = sat_bump(rcv_total);
      if (h.pid >= 32'(cfg_producers) || h.seq >= 32'(cfg_msgs) ||
          slot >= 64'(STORE_BITS_DEF)) begin
        rng_total = sat_bump(rng_total);
        t.verdict = VERDICT_RANGE;
      end else if (seen_map[slot]) begin
        dup_total = sat_bump(dup_total);
        t.verdict = VERDICT_DUPLICATE;
      end else begin
        seen_map[slot] = 1'b1;
        t.verdict      = VERDICT_NEW;
      end
    end
    t.received     = rcv_total;
    t.duplicates   = dup_total;
    t.range_errors = rng_total;
    t.malformed    = mal_total;
    return t;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               result_index, field, got, want);
  endtask

  // Header driver: advance on acceptance, predict each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    header_t h;
    if (!rst_ni) begin
      hdr_ch.valid    <= 1'b0;
      hdr_ch.src_id   <= '0;
      hdr_ch.seq      <= '0;
      hdr_ch.body_len <= '0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        h.pid  = hdr_ch.src_id;
        h.seq  = hdr_ch.seq;
        h.plen = hdr_ch.body_len;
        due_tallies.push_back(tally_header(h));
      end
      if (!hdr_ch.valid || hdr_ch.ready) begin
        if (header_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          h = header_queue.pop_front();
          hdr_ch.valid    <= 1'b1;
          hdr_ch.src_id   <= h.pid;
          hdr_ch.seq      <= h.seq;
          hdr_ch.body_len <= h.plen;
        end else begin
          hdr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest expected tally
  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_tallies.size() == 0) begin
          report_mismatch("unexpected result", 32'(res_ch.verdict), '0);
        end else begin
          want = due_tallies.pop_front();
          if (res_ch.verdict !== want.verdict)
            report_mismatch("verdict", 32'(res_ch.verdict), 32'(want.verdict));
          if (res_ch.received_count !== want.received)
            report_mismatch("received_count", res_ch.received_count, want.received);
          if (res_ch.duplicate_count !== want.duplicates)
            report_mismatch("duplicate_count", res_ch.duplicate_count, want.duplicates);
          if (res_ch.out_of_range_count !== want.range_errors)
            report_mismatch("out_of_range_count", res_ch.out_of_range_count,
                            want.range_errors);
          if (res_ch.malformed_count !== want.malformed)
            report_mismatch("malformed_count", res_ch.malformed_count, want.malformed);
        end
        result_index++;
      end
      res_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the pipeline fills and stalls its input
  initial begin
    rx_hold = 1'b0;
    wait (pressure_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic queue_header(input logic [31:0] pid, input logic [31:0] seq,
                              input logic [31:0] plen);
    header_t h;
    h.pid  = pid;
    h.seq  = seq;
    h.plen = plen;
    header_queue.push_back(h);
  endtask

  // Write all three registers, then mirror them in the predictor
  task automatic set_config(input int unsigned producers, input int unsigned msgs,
                            input int unsigned plen);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PRODUCER_COUNT;
    cfg_data <= CFG_DATA_W'(producers);
    @(posedge clk_i);
    cfg_idx  <= CFG_MSGS_PER_PROD;
    cfg_data <= CFG_DATA_W'(msgs);
    @(posedge clk_i);
    cfg_idx  <= CFG_EXPECTED_LEN;
    cfg_data <= CFG_DATA_W'(plen);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_producers = PID_W'(producers);
    cfg_msgs      = MPP_W'(msgs);
    cfg_len       = LEN_W'(plen);
    @(negedge clk_i);
  endtask

  // Hold until every header is accepted and every tally has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (header_queue.size() != 0 || hdr_ch.valid || due_tallies.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Mostly well-formed headers, with repeats, boundary ids, bad lengths and noise
  task automatic queue_random_header();
    int unsigned pick;
    int unsigned producers;
    int unsigned msgs;
    logic [31:0] pid, seq, plen;
    header_t     h;
    pick      = $urandom_range(99);
    producers = cfg_producers;
    msgs      = cfg_msgs;
    plen      = 32'(cfg_len);
    pid       = (producers != 0) ? $urandom_range(producers - 1) : $urandom();
    seq       = (msgs != 0) ? $urandom_range(msgs - 1) : $urandom();
    if (pick < 30 && recent_hdrs.size() != 0) begin
      h   = recent_hdrs[$urandom_range(recent_hdrs.size() - 1)];
      pid = h.pid;
      seq = h.seq;
    end else if (pick >= 70 && pick < 78) begin
      case ($urandom_range(2))
        0:       pid = producers + $urandom_range(2);
        1:       seq = msgs + $urandom_range(2);
        default: seq = (msgs != 0) ? msgs - 1 : 0;
      endcase
    end else if (pick >= 78 && pick < 88) begin
      case ($urandom_range(2))
        0:       plen = plen + 1;
        1:       plen = plen - 1;
        default: plen = $urandom();
      endcase
    end else if (pick >= 88) begin
      pid = $urandom();
      seq = $urandom();
      if ($urandom_range(1) != 0) plen = $urandom();
    end
    // keep the sentinel for the end of the run
    if (pid == SENTINEL_ID) pid = '0;
    queue_header(pid, seq, plen);
    h.pid  = pid;
    h.seq  = seq;
    h.plen = plen;
    recent_hdrs.push_back(h);
    if (recent_hdrs.size() > RECENT_DEPTH) void'(recent_hdrs.pop_front());
  endtask

  // Main sequence
  initial begin
    int unsigned msgs;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_PRODUCER_COUNT;
    cfg_data        = '0;
    hdr_ch.valid    = 1'b0;
    hdr_ch.src_id   = '0;
    hdr_ch.seq      = '0;
    hdr_ch.body_len = '0;
    res_ch.ready    = 1'b0;
    cfg_producers   = PC_RESET;
    cfg_msgs        = MPP_RESET;
    cfg_len         = EXP_LEN_RESET;
    rcv_total       = '0;
    dup_total       = '0;
    rng_total       = '0;
    mal_total       = '0;
    run_done        = 1'b0;
    mismatch_count  = 0;
    result_index    = 0;
    pressure_go     = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, one valid slot
    queue_header(0, 0, 64);
    queue_header(0, 0, 64);
    queue_header(1, 0, 64);
    queue_header(0, 1, 64);
    queue_header(0, 0, 63);
    queue_header(0, 0, 0);
    queue_header(0, 0, 32'hFFFF_FFFF);
    queue_header(32'hFFFF_FFFE, 32'hFFFF_FFFF, 64);
    queue_header(0, 32'hFFFF_FFFF, 64);
    wait_drained();

    // Directed: 256 producers of 65536 messages, slot past the end of the store
    set_config(256, 65536, 512);
    queue_header(255, 0, 512);
    queue_header(0, 65535, 512);
    queue_header(0, 65535, 512);
    queue_header(1, 0, 512);
    queue_header(0, 65536, 512);
    queue_header(256, 0, 512);
    queue_header(0, 1234, 513);
    wait_drained();

    // Directed: zero registers, nothing is in range
    set_config(0, 0, 0);
    queue_header(0, 0, 0);
    queue_header(0, 0, 1);
    wait_drained();

    // Directed: all-ones registers, seen bits survive the change
    set_config(511, 131071, 1023);
    queue_header(510, 0, 1023);
    queue_header(0, 131070, 1023);
    queue_header(0, 100, 1023);
    queue_header(0, 0, 1023);
    wait_drained();
    set_config(1, 1, 1);
    queue_header(0, 0, 1);
    wait_drained();

    // Random phases over several settings and idle patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(4, 8, 64);
        1: set_config(256, 256, 512);
        2: set_config(1, 65536, 1);
        3: set_config(16, 4096, 100);
        4: set_config(300, 300, 200);
        default: begin
          case ($urandom_range(2))
            0:       msgs = $urandom_range(64, 1);
            1:       msgs = $urandom_range(4096, 1);
            default: msgs = 65536;
          endcase
          set_config($urandom_range(256, 1), msgs, $urandom_range(512, 1));
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      if (ph == 4) pressure_go = 1'b1;
      repeat (PHASE_ITEMS) queue_random_header();
      wait_drained();
    end

    // End of run: sentinel, then headers that must all report stopped
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    queue_header(SENTINEL_ID, $urandom(), $urandom());
    queue_header(0, 0, 32'(cfg_len));
    queue_header(SENTINEL_ID, 0, 0);
    repeat (3) queue_header($urandom(), $urandom(), $urandom());
    wait_drained();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
